// ----- rtl/bil_pkg.sv -----
// ---------------------------------------------------------------------------
// bil_pkg
// shared widths, request and status codes, and controller/datapath structs
// ---------------------------------------------------------------------------
`default_nettype none

package bil_pkg;

    localparam int CNT_W        = 5;
    localparam int POS_W        = 4;
    localparam int REQ_W        = 3;
    localparam int VAL_W        = 32;
    localparam int STAT_W       = 2;
    localparam int DEF_CAPACITY = 16;

    localparam logic [CNT_W-1:0] DEF_LIMIT = 5'd16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // source of the read value in a result
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_DATA,
        RD_FAIL
    } t_rd_sel;

    typedef struct packed {
        logic              load;
        logic              setup;
        logic              shift;
        logic              put;
        logic              drop;
        logic              rd;
        logic              finish;
        logic [STAT_W-1:0] status;
        t_rd_sel           rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             pos_lt_cnt;
        logic             cnt_zero;
        logic             pos_zero;
        logic             moves_done;
        logic             out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/bil_if.sv -----
// ---------------------------------------------------------------------------
// bil_if
// request, result and configuration channels of the list core
// ---------------------------------------------------------------------------
`default_nettype none

interface bil_req_if import bil_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;

    modport source (output valid, req_type, position, value_in, input ready);
    modport sink   (input valid, req_type, position, value_in, output ready);
endinterface

interface bil_rsp_if import bil_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;
    logic                    is_full;

    modport source (output valid, status, read_value, entry_count, is_empty, is_full,
                    input ready);
    modport sink   (input valid, status, read_value, entry_count, is_empty, is_full,
                    output ready);
endinterface

interface bil_cfg_if import bil_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bil_ctrl.sv -----
// ---------------------------------------------------------------------------
// bil_ctrl
// request sequencer: decodes the request and steps the datapath
// ---------------------------------------------------------------------------
`default_nettype none

module bil_ctrl import bil_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [STAT_W-1:0] r_status, n_status;
    t_rd_sel           r_rd_sel, n_rd_sel;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_rd_sel = r_rd_sel;
        o_cmd        = '0;
        o_cmd.status = r_status;
        o_cmd.rd_sel = r_rd_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                n_status = ST_DONE;
                n_rd_sel = RD_ZERO;
                n_state  = S_DONE;
                case (i_sts.req)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.setup = 1'b1;
                            n_state     = S_SHIFT;
                        end
                    end
                    REQ_INSERT: begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                        end else if (i_sts.pos_lt_cnt || (i_sts.pos_zero && i_sts.cnt_zero)) begin
                            o_cmd.setup = 1'b1;
                            n_state     = S_SHIFT;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    REQ_DELETE: begin
                        if (i_sts.pos_lt_cnt) begin
                            o_cmd.setup = 1'b1;
                            n_state     = S_SHIFT;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    REQ_READ: begin
                        if (i_sts.pos_lt_cnt) begin
                            o_cmd.rd = 1'b1;
                            n_rd_sel = RD_DATA;
                        end else begin
                            n_status = ST_RANGE;
                            n_rd_sel = RD_FAIL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                if (i_sts.moves_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_DRAIN: begin
                // last moved entry was written as the shift loop ended
                if (i_sts.req == REQ_DELETE) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_DONE;
            r_rd_sel <= RD_ZERO;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_rd_sel <= n_rd_sel;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bil_datapath.sv -----
// ---------------------------------------------------------------------------
// bil_datapath
// entry store, count and limit registers, shift pointers and result register
// ---------------------------------------------------------------------------
`default_nettype none

module bil_datapath import bil_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_sts                      o_sts,
    input  wire logic [REQ_W-1:0]        i_req_type,
    input  wire logic [POS_W-1:0]        i_position,
    input  wire logic signed [VAL_W-1:0] i_value_in,
    input  wire logic                    i_cfg_valid,
    input  wire logic [CNT_W-1:0]        i_cfg_data,
    input  wire logic                    i_rsp_ready,
    output logic                         o_rsp_valid,
    output logic [STAT_W-1:0]            o_status,
    output logic signed [VAL_W-1:0]      o_read_value,
    output logic [CNT_W-1:0]             o_entry_count,
    output logic                         o_is_empty,
    output logic                         o_is_full
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (AW > CNT_W) ? AW : CNT_W;

    logic [VAL_W-1:0] mem [CAPACITY];

    logic [REQ_W-1:0]        r_req;
    logic [POS_W-1:0]        r_pos;
    logic [VAL_W-1:0]        r_val;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_limit;
    logic [PW-1:0]           r_ptr;
    logic [PW-1:0]           r_tgt;
    logic [VAL_W-1:0]        r_q;
    logic                    r_wp_valid;
    logic [AW-1:0]           r_wp_addr;
    logic                    r_o_valid;
    logic [STAT_W-1:0]       r_o_status;
    logic signed [VAL_W-1:0] r_o_rd;
    logic [CNT_W-1:0]        r_o_cnt;
    logic                    r_o_empty;
    logic                    r_o_full;

    logic [PW-1:0] cnt_x;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] ins_at;
    logic [PW-1:0] rd_addr_x;
    logic [PW-1:0] dst_x;
    logic          is_del;
    logic          full;
    logic          rd_en;

    assign cnt_x  = PW'(r_count);
    assign pos_x  = PW'(r_pos);
    assign is_del = (r_req == REQ_DELETE);
    assign full   = (r_count >= r_limit) || (32'(r_count) >= 32'(CAPACITY));

    always_comb begin
        case (r_req)
            REQ_PUSH_FRONT: ins_at = '0;
            REQ_PUSH_BACK:  ins_at = cnt_x;
            default:        ins_at = pos_x;
        endcase
    end

    // insert moves entries up walking down, delete moves them down walking up
    assign rd_en     = i_cmd.shift | i_cmd.rd;
    assign rd_addr_x = i_cmd.rd ? pos_x : (is_del ? r_ptr : r_ptr - PW'(1));
    assign dst_x     = is_del ? r_ptr - PW'(1) : r_ptr;

    assign o_sts.req        = r_req;
    assign o_sts.full       = full;
    assign o_sts.pos_lt_cnt = ({1'b0, r_pos} < r_count);
    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.pos_zero   = (r_pos == '0);
    assign o_sts.moves_done = (r_ptr == r_tgt);
    assign o_sts.out_free   = !r_o_valid || i_rsp_ready;

    // store, read register and payload
    always_ff @(posedge i_clk) begin
        if (r_wp_valid) begin
            mem[r_wp_addr] <= r_q;
        end else if (i_cmd.put) begin
            mem[r_tgt[AW-1:0]] <= r_val;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr_x[AW-1:0]];
        end
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_pos <= i_position;
            r_val <= i_value_in;
        end
        if (i_cmd.setup) begin
            r_ptr <= is_del ? pos_x + PW'(1) : cnt_x;
            r_tgt <= is_del ? cnt_x : ins_at;
        end else if (i_cmd.shift) begin
            r_ptr <= is_del ? r_ptr + PW'(1) : r_ptr - PW'(1);
        end
        r_wp_addr <= dst_x[AW-1:0];
        if (i_cmd.finish) begin
            r_o_status <= i_cmd.status;
            r_o_cnt    <= r_count;
            r_o_empty  <= (r_count == '0);
            r_o_full   <= full;
            case (i_cmd.rd_sel)
                RD_DATA: r_o_rd <= r_q;
                RD_FAIL: r_o_rd <= '1;
                default: r_o_rd <= '0;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_limit    <= DEF_LIMIT;
            r_wp_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.put) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.drop) begin
                r_count <= r_count - CNT_W'(1);
            end
            r_wp_valid <= i_cmd.shift;
            if (i_cmd.finish) begin
                r_o_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_read_value  = r_o_rd;
    assign o_entry_count = r_o_cnt;
    assign o_is_empty    = r_o_empty;
    assign o_is_full     = r_o_full;

endmodule

`default_nettype wire

// ----- rtl/bounded_indexed_list_core.sv -----
// sequence: a read, a rejected or an unknown request goes from decode straight to its
//   result; a push or insert runs the shift loop and a final write, a delete the shift loop and a drop
// throughput: one item at a time; the store has
//   one write and one read port, so a shift moves one entry per cycle
// reset: synchronous active low; count cleared, limit back to 16, no result pending;
//   the store is not cleared and only entries below the count are ever read
// ---------------------------------------------------------------------------
// bounded_indexed_list_core
// ordered list of signed values in a fixed store with push, insert, delete and read
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_indexed_list_core import bil_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bil_req_if.sink    i_req,
    bil_rsp_if.source  o_rsp,
    bil_cfg_if.sink    i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    // the limit register takes a write in any cycle
    assign i_cfg.ready = 1'b1;
    // one item at a time: taken only when the sequencer is idle
    assign i_req.ready = in_ready;

    // sequencer: decode, shift loop, final write, result hand-off
    bil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // store, count, limit and result register; the result register lets the
    // next item in while a result still waits downstream
    bil_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req.req_type),
        .i_position    (i_req.position),
        .i_value_in    (i_req.value_in),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_read_value  (o_rsp.read_value),
        .o_entry_count (o_rsp.entry_count),
        .o_is_empty    (o_rsp.is_empty),
        .o_is_full     (o_rsp.is_full)
    );

endmodule

`default_nettype wire

// ----- rtl/bil_checker.sv -----
// ---------------------------------------------------------------------------
// bil_checker
// result-port checks of the list core, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module bil_checker import bil_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_valid,
    input wire logic                    i_ready,
    input wire logic [STAT_W-1:0]       i_status,
    input wire logic signed [VAL_W-1:0] i_read_value,
    input wire logic [CNT_W-1:0]        i_entry_count,
    input wire logic                    i_is_empty,
    input wire logic                    i_is_full
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_read_value)
            && $stable(i_entry_count))
        else $error("stalled result changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_is_empty == (i_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_FULL) |-> i_is_full && (i_read_value == '0))
        else $error("rejected push or insert without full list");

    a_range_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_RANGE) |-> (i_read_value == '0) || (i_read_value == '1))
        else $error("out of range item with bad read value");

endmodule

bind bounded_indexed_list_core bil_checker u_bil_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_rsp.valid),
    .i_ready       (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_read_value  (o_rsp.read_value),
    .i_entry_count (o_rsp.entry_count),
    .i_is_empty    (o_rsp.is_empty),
    .i_is_full     (o_rsp.is_full)
);

`default_nettype wire

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// self-checking bench for bounded_indexed_list_core: a scripted opening run of
// requests and limit writes, then random phases biased to grow or shrink the
// list under several limits, all results checked against the scripted answer or a shadow list model
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bil_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          LIST_DEPTH   = DEF_CAPACITY;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 50;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    // request codes the core must answer without touching the list
    localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        entry_count;
        logic                    is_empty;
        logic                    is_full;
    } t_list_rsp;

    typedef enum logic {ROW_REQUEST, ROW_LIMIT} t_row_kind;

    // a limit row carries the new limit in val
    typedef struct packed {
        t_row_kind               kind;
        logic [REQ_W-1:0]        req;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        logic                    typed;
        t_list_rsp               rsp;
    } t_script_row;

    localparam t_list_rsp NO_RSP = '0;

    localparam int SCRIPT_LEN = 28;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // empty list right after reset
        '{ROW_REQUEST, REQ_READ,       4'h0, 32'h0000_0000, 1'b1,
          '{ST_RANGE, -32'sd1, 5'd0, 1'b1, 1'b0}},
        '{ROW_REQUEST, REQ_DELETE,     4'h0, 32'h0000_0000, 1'b1,
          '{ST_RANGE, 32'sd0, 5'd0, 1'b1, 1'b0}},
        '{ROW_REQUEST, REQ_INSERT,     4'h3, 32'h0000_0001, 1'b1,
          '{ST_RANGE, 32'sd0, 5'd0, 1'b1, 1'b0}},
        // insert at 0 into an empty list is allowed
        '{ROW_REQUEST, REQ_INSERT,     4'h0, 32'h7FFF_FFFF, 1'b1,
          '{ST_DONE, 32'sd0, 5'd1, 1'b0, 1'b0}},
        '{ROW_REQUEST, REQ_PUSH_FRONT, 4'h0, 32'h8000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_PUSH_BACK,  4'hF, 32'hFFFF_FFFF, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_PUSH_BACK,  4'h0, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_READ,       4'h0, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_READ,       4'h3, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_INSERT,     4'h1, 32'h5A5A_5A5A, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_READ,       4'h1, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_DELETE,     4'h0, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_READ,       4'hF, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_SPARE_5,    4'hF, 32'hFFFF_FFFF, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_SPARE_6,    4'h0, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_SPARE_7,    4'hA, 32'h1234_5678, 1'b0, NO_RSP},
        // delete the last entry, then insert one past the end
        '{ROW_REQUEST, REQ_DELETE,     4'h3, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_INSERT,     4'h3, 32'h0000_0002, 1'b0, NO_RSP},
        // limit below the count: full wins over range, deletes free it again
        '{ROW_LIMIT,   REQ_PUSH_FRONT, 4'h0, 32'h0000_0002, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_PUSH_BACK,  4'h0, 32'h0000_0003, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_INSERT,     4'h0, 32'h0000_0004, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_INSERT,     4'hF, 32'h0000_0005, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_DELETE,     4'h0, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_DELETE,     4'h1, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_PUSH_FRONT, 4'h0, 32'h0000_0001, 1'b0, NO_RSP},
        // limit of zero rejects every push and insert
        '{ROW_LIMIT,   REQ_PUSH_FRONT, 4'h0, 32'h0000_0000, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_PUSH_BACK,  4'h0, 32'h0000_0006, 1'b0, NO_RSP},
        '{ROW_REQUEST, REQ_READ,       4'h1, 32'h0000_0000, 1'b0, NO_RSP}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bil_req_if req_ch ();
    bil_rsp_if rsp_ch ();
    bil_cfg_if cfg_ch ();

    bounded_indexed_list_core #(
        .CAPACITY (LIST_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow copy of the list and its limit
    logic signed [VAL_W-1:0] shadow_entries [LIST_DEPTH];
    int                      shadow_count;
    logic [CNT_W-1:0]        shadow_limit;

    t_list_rsp pending_results [$];
    int        mismatches = 0;
    bit        no_idle    = 1'b0;
    bit        req_held   = 1'b0;
    int        stall_left = 0;

    function automatic int eff_limit();
        return (int'(shadow_limit) < LIST_DEPTH) ? int'(shadow_limit) : LIST_DEPTH;
    endfunction

    // applies one request to the shadow list and returns the result it gives
    function automatic t_list_rsp list_apply(input logic [REQ_W-1:0] kind,
                                             input logic [POS_W-1:0] pos,
                                             input logic signed [VAL_W-1:0] val);
        t_list_rsp r;
        int        slot;
        int        p;
        bit        at_limit;
        r        = '0;
        r.status = ST_DONE;
        slot     = -1;
        p        = int'(pos);
        at_limit = shadow_count >= eff_limit();
        case (kind)
            REQ_PUSH_FRONT: begin
                if (at_limit) r.status = ST_FULL;
                else slot = 0;
            end
            REQ_PUSH_BACK: begin
                if (at_limit) r.status = ST_FULL;
                else slot = shadow_count;
            end
            REQ_INSERT: begin
                // full is checked before range
                if (at_limit) r.status = ST_FULL;
                else if (p < shadow_count || (p == 0 && shadow_count == 0)) slot = p;
                else r.status = ST_RANGE;
            end
            REQ_DELETE: begin
                if (p < shadow_count) begin
                    for (int i = p; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            REQ_READ: begin
                if (p < shadow_count) begin
                    r.read_value = shadow_entries[p];
                end else begin
                    r.status     = ST_RANGE;
                    r.read_value = -32'sd1;
                end
            end
            default: ;
        endcase
        if (slot >= 0) begin
            for (int i = shadow_count; i > slot; i--)
                shadow_entries[i] = shadow_entries[i - 1];
            shadow_entries[slot] = val;
            shadow_count++;
        end
        r.entry_count = CNT_W'(shadow_count);
        r.is_empty    = shadow_count == 0;
        r.is_full     = shadow_count >= eff_limit();
        return r;
    endfunction

    // mostly back to back, sometimes a short pause, rarely a long one; never while no_idle
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h", $time, what,
                     want, got);
            mismatches++;
        end
    endfunction

    task automatic wait_drained();
        if (req_held) begin
            req_ch.valid <= 1'b0;
            req_held = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val, input logic typed,
                                input t_list_rsp typed_rsp);
        t_list_rsp predicted;
        int        gap;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.position <= pos;
        req_ch.value_in <= val;
        req_held = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = list_apply(kind, pos, val);
        pending_results.push_back(typed ? typed_rsp : predicted);
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            req_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] lim);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= lim;
        do @(posedge i_clk); while (!cfg_ch.ready);
        shadow_limit = lim;
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: random back-pressure and the field-by-field comparison
    always @(posedge i_clk) begin : result_check
        t_list_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: unexpected result, status %0d value 0x%h count %0d",
                             $time, rsp_ch.status, rsp_ch.read_value, rsp_ch.entry_count);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, rsp_ch.status);
                    check_field("read_value", want.read_value, rsp_ch.read_value);
                    check_field("entry_count", want.entry_count, rsp_ch.entry_count);
                    check_field("is_empty", want.is_empty, rsp_ch.is_empty);
                    check_field("is_full", want.is_full, rsp_ch.is_full);
                end
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        logic [REQ_W-1:0]        kind;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        logic [CNT_W-1:0]        lim;
        int                      grow;
        int                      r;

        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_PUSH_FRONT;
        req_ch.position = '0;
        req_ch.value_in = '0;
        rsp_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        foreach (shadow_entries[i]) shadow_entries[i] = '0;
        shadow_count = 0;
        shadow_limit = DEF_LIMIT;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < SCRIPT_LEN; k++) begin
            if (SCRIPT[k].kind == ROW_LIMIT)
                write_limit(SCRIPT[k].val[CNT_W-1:0]);
            else
                send_request(SCRIPT[k].req, SCRIPT[k].pos, SCRIPT[k].val, SCRIPT[k].typed,
                             SCRIPT[k].rsp);
        end

        // random phases, each opened by a limit write; even phases favour pushes and inserts, odd ones less so
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0, 3, 7: lim = DEF_LIMIT;
                1:       lim = 5'd1;
                4:       lim = 5'd2;
                5:       lim = CNT_W'($urandom_range(17, 31));
                default: lim = CNT_W'($urandom_range(1, 16));
            endcase
            write_limit(lim);
            no_idle = (ph == 2 || ph == 5);
            grow    = (ph % 2 == 0) ? 70 : 35;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the sender until everything in flight has come back
                if (n == PHASE_ITEMS / 2 && ph % 2 == 1) wait_drained();
                r = $urandom_range(0, 99);
                if (r < grow)
                    kind = REQ_W'($urandom_range(REQ_PUSH_FRONT, REQ_INSERT));
                else if (r < 96)
                    kind = $urandom_range(0, 1) ? REQ_DELETE : REQ_READ;
                else
                    kind = REQ_W'($urandom_range(REQ_SPARE_5, REQ_SPARE_7));
                if (shadow_count > 0 && $urandom_range(0, 9) < 8)
                    pos = POS_W'($urandom_range(0, shadow_count - 1));
                else
                    pos = POS_W'($urandom);
                case ($urandom_range(0, 9))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7FFF_FFFF;
                    2:       val = -32'sd1;
                    3:       val = 32'sd0;
                    default: val = $urandom;
                endcase
                send_request(kind, pos, val, 1'b0, NO_RSP);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bil_pkg.sv
rtl/bil_if.sv
rtl/bil_ctrl.sv
rtl/bil_datapath.sv
rtl/bounded_indexed_list_core.sv
rtl/bil_checker.sv
tb/tb.sv
